// ----- src/b2b_pkg.sv -----
// Shared types, constants and helper functions of the BLAKE2b hash engine.
// No dependencies; every other file of the block imports this package.
package b2b_pkg;

    localparam int WORD_W      = 64;
    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 12;
    localparam int BLOCK_BYTES = 128;

    localparam logic [1:0] CFG_DIGEST_LEN = 2'd0;
    localparam logic [1:0] CFG_KEY_LEN    = 2'd1;

    localparam logic [63:0] PARAM_CONST = 64'h0000_0000_0101_0000;

    localparam logic [7:0][63:0] IV = {
        64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b,
        64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
        64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b,
        64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
    };

    localparam logic [3:0] SIGMA [10][16] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
        '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
          4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
        '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
          4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
        '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
          4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
        '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
          4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
        '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
          4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
        '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
          4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
        '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
          4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
        '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
          4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
    };

    typedef struct packed {
        logic [63:0] message_word;
        logic [3:0]  valid_bytes;
        logic        last_item;
    } t_in;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [3:0]  digest_bytes;
        logic        last_word;
    } t_out;

    typedef struct packed {
        logic        en;
        logic [3:0]  addr;
        logic [63:0] data;
    } t_ram_wr;

    typedef struct packed {
        logic start;
        logic final_blk;
    } t_mix_ctrl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STORE,
        S_LAST,
        S_PAD,
        S_CSTART,
        S_CWAIT,
        S_OUT
    } t_state;

    // Message schedule lookup; the round index wraps after ten rounds.
    function automatic logic [3:0] sigma_sel(input logic [3:0] rnd, input logic [3:0] pos);
        logic [3:0] r10;
        r10 = (rnd >= 4'd10) ? rnd - 4'd10 : rnd;
        return SIGMA[r10][pos];
    endfunction

    function automatic logic [63:0] rotr64(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // Keeps the first nb bytes of a word and clears the rest.
    function automatic logic [63:0] byte_mask(input logic [63:0] w, input logic [3:0] nb);
        logic [63:0] r;
        r = w;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) >= nb) begin
                r[i*8 +: 8] = 8'h00;
            end
        end
        return r;
    endfunction

    function automatic logic [6:0] eff_dlen(input logic [6:0] raw);
        logic [6:0] r;
        if (raw == 7'd0) begin
            r = 7'd1;
        end else if (raw > 7'd64) begin
            r = 7'd64;
        end else begin
            r = raw;
        end
        return r;
    endfunction

    function automatic logic [6:0] eff_klen(input logic [6:0] raw);
        return (raw > 7'd64) ? 7'd64 : raw;
    endfunction

endpackage

// ----- src/b2b_msg_ram.sv -----
// Sixteen-word message block buffer with one write port and one registered read port.
// Depends on b2b_pkg for the write port struct.
module b2b_msg_ram (
    input  logic                 i_clk,
    input  b2b_pkg::t_ram_wr     i_wr,
    input  logic                 i_rd_en,
    input  logic [3:0]           i_rd_addr,
    output logic [63:0]          o_rd_data
);
    import b2b_pkg::*;

    logic [63:0] r_mem [BLOCK_WORDS];
    logic [63:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/b2b_mix_unit.sv -----
// Compression unit: one shared quarter-G datapath stepped by a round/G/phase sequencer.
// The working vector sits in four rotating rows. Depends on b2b_pkg.
module b2b_mix_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  b2b_pkg::t_mix_ctrl     i_ctrl,
    input  logic [7:0][63:0]       i_h,
    input  logic [1:0][63:0]       i_t,
    input  logic [63:0]            i_msg,
    output logic                   o_rd_en,
    output logic [3:0]             o_rd_addr,
    output logic                   o_done,
    output logic [15:0][63:0]      o_v
);
    import b2b_pkg::*;

    logic [3:0][3:0][63:0] r_v, n_v;
    logic [3:0][3:0][63:0] step_v;
    logic [3:0]            r_round, n_round;
    logic [2:0]            r_g, n_g;
    logic [2:0]            r_ph, n_ph;
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [63:0]           a_new, b_new, c_new, d_new;
    logic [3:0][1:0]       rot_amt;

    // Sequencer.
    always_comb begin
        n_round = r_round;
        n_g     = r_g;
        n_ph    = r_ph;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_ctrl.start) begin
            n_round = '0;
            n_g     = '0;
            n_ph    = '0;
            n_busy  = 1'b1;
        end else if (r_busy) begin
            if (r_ph == 3'd4) begin
                n_ph = '0;
                n_g  = r_g + 3'd1;
                if (r_g == 3'd7) begin
                    n_round = r_round + 4'd1;
                    if (r_round == 4'(ROUNDS - 1)) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end
                end
            end else begin
                n_ph = r_ph + 3'd1;
            end
        end
    end

    assign o_rd_en   = r_busy && (r_ph == 3'd0 || r_ph == 3'd1);
    assign o_rd_addr = sigma_sel(r_round, {r_g, r_ph[0]});

    // Quarter-G datapath on the first column of the rows.
    always_comb begin
        a_new = r_v[0][0];
        b_new = r_v[1][0];
        c_new = r_v[2][0];
        d_new = r_v[3][0];
        case (r_ph)
            3'd1: begin
                a_new = r_v[0][0] + r_v[1][0] + i_msg;
                d_new = rotr64(r_v[3][0] ^ a_new, 32);
            end
            3'd2: begin
                c_new = r_v[2][0] + r_v[3][0];
                b_new = rotr64(r_v[1][0] ^ c_new, 24);
            end
            3'd3: begin
                a_new = r_v[0][0] + r_v[1][0] + i_msg;
                d_new = rotr64(r_v[3][0] ^ a_new, 16);
            end
            3'd4: begin
                c_new = r_v[2][0] + r_v[3][0];
                b_new = rotr64(r_v[1][0] ^ c_new, 63);
            end
            default: begin
            end
        endcase
        step_v       = r_v;
        step_v[0][0] = a_new;
        step_v[1][0] = b_new;
        step_v[2][0] = c_new;
        step_v[3][0] = d_new;
    end

    // Row rotation after each G; it also enters and leaves the diagonal layout.
    always_comb begin
        case (r_g)
            3'd3:    rot_amt = {2'd0, 2'd3, 2'd2, 2'd1};
            3'd7:    rot_amt = {2'd2, 2'd3, 2'd0, 2'd1};
            default: rot_amt = {2'd1, 2'd1, 2'd1, 2'd1};
        endcase
    end

    always_comb begin
        n_v = r_v;
        if (i_ctrl.start) begin
            for (int i = 0; i < 8; i++) begin
                n_v[i/4][i%4]       = i_h[i];
                n_v[2 + i/4][i%4]   = IV[i];
            end
            n_v[3][0] = IV[4] ^ i_t[0];
            n_v[3][1] = IV[5] ^ i_t[1];
            n_v[3][2] = i_ctrl.final_blk ? ~IV[6] : IV[6];
        end else if (r_busy) begin
            if (r_ph == 3'd4) begin
                for (int row = 0; row < 4; row++) begin
                    for (int col = 0; col < 4; col++) begin
                        n_v[row][col] = step_v[row][2'(col) + rot_amt[row]];
                    end
                end
            end else begin
                n_v = step_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
            r_g     <= '0;
            r_ph    <= '0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_round <= n_round;
            r_g     <= n_g;
            r_ph    <= n_ph;
        end
        r_v <= n_v;
    end

    assign o_done = r_done;
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            o_v[i] = r_v[i/4][i%4];
        end
    end

endmodule

// ----- src/blake2b_hash_engine_top.sv -----
// Top level of the BLAKE2b hash engine: channel control, byte counter, chain value.
// Depends on b2b_pkg, b2b_msg_ram and b2b_mix_unit.
//
// The input channel (i_valid, o_stall, i_data) carries one 64-bit little-endian message
// word per transaction. Every word but the last counts as eight bytes; the last word
// (last_item set) may carry zero to eight bytes. In keyed mode the host first sends the
// zero-padded 128-byte key block as ordinary data.
// The output channel (o_valid, i_stall, o_data) returns the digest, one 64-bit word per
// transaction, ceil(digest size in bytes / 8) transactions, the final one flagged by
// last_word.
// The block takes one word at a time. A word that does not follow a full block goes
// straight to the store step. A word that follows a full block first triggers a
// compression of that block: 12 rounds of 8 G functions, each G run as five phases of
// one shared 64-bit adder/rotator. The last word adds zero padding of the buffer (one
// word per cycle) and a final compression. When the receiver stalls, the current digest
// word is held and no new message is taken until the whole digest has been delivered.
// Reset is synchronous and active low: registers return to 64-byte digest, no key,
// and the chain value is loaded from the parameter block. A configuration write, or the
// end of a digest, reloads the chain value in the following cycle, during which the
// input is stalled.
module blake2b_hash_engine_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  b2b_pkg::t_in       i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output b2b_pkg::t_out      o_data,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [6:0]         i_cfg_data
);
    import b2b_pkg::*;

    t_state            r_state, n_state;
    logic [7:0][63:0]  r_h, n_h;
    logic [63:0]       r_t0, n_t0, r_t1, n_t1;
    logic [7:0]        r_buf, n_buf;
    logic [4:0]        r_pad, n_pad;
    logic [2:0]        r_k, n_k;
    logic [63:0]       r_word, n_word;
    logic [3:0]        r_nb, n_nb;
    logic              r_last, n_last;
    logic              r_final, n_final;
    logic [6:0]        r_dlen, n_dlen, r_klen, n_klen;
    logic              r_restart, n_restart;

    logic              in_acc;
    logic [3:0]        nb_eff;
    logic [6:0]        dl;
    logic [7:0]        cnt_sum;
    logic [2:0]        last_k;
    logic [8:0]        pad_sum;
    logic [7:0]        add_n;
    logic              add_en;
    logic [64:0]       t0_sum;

    t_ram_wr           ram_wr;
    logic              rd_en;
    logic [3:0]        rd_addr;
    logic [63:0]       rd_data;
    t_mix_ctrl         mix_ctrl;
    logic              mix_done;
    logic [15:0][63:0] mix_v;

    b2b_msg_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    b2b_mix_unit u_mix (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (mix_ctrl),
        .i_h       (r_h),
        .i_t       ({r_t1, r_t0}),
        .i_msg     (rd_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .o_done    (mix_done),
        .o_v       (mix_v)
    );

    assign in_acc  = i_valid && !o_stall;
    assign nb_eff  = (!i_data.last_item || i_data.valid_bytes > 4'd8) ? 4'd8
                                                                      : i_data.valid_bytes;
    assign dl      = eff_dlen(r_dlen);
    assign cnt_sum = {1'b0, dl} + 8'd7;
    assign last_k  = 3'(cnt_sum[6:3] - 4'd1);
    assign pad_sum = {1'b0, r_buf} + 9'd7;
    assign t0_sum  = {1'b0, r_t0} + {57'd0, add_n};

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (nb_eff != 4'd0 && r_buf >= 8'(BLOCK_BYTES)) begin
                        n_state = S_CSTART;
                    end else begin
                        n_state = S_STORE;
                    end
                end
            end
            S_STORE:  n_state = r_last ? S_LAST : S_IDLE;
            S_LAST:   n_state = S_PAD;
            S_PAD:    n_state = r_pad[4] ? S_CSTART : S_PAD;
            S_CSTART: n_state = S_CWAIT;
            S_CWAIT: begin
                if (mix_done) begin
                    n_state = r_final ? S_OUT : S_STORE;
                end
            end
            S_OUT: begin
                if (!i_stall && r_k == last_k) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath and output logic.
    always_comb begin
        n_h       = r_h;
        n_buf     = r_buf;
        n_pad     = r_pad;
        n_k       = r_k;
        n_word    = r_word;
        n_nb      = r_nb;
        n_last    = r_last;
        n_final   = r_final;
        n_dlen    = r_dlen;
        n_klen    = r_klen;
        n_restart = 1'b0;
        add_en    = 1'b0;
        add_n     = 8'(BLOCK_BYTES);
        ram_wr    = '{en: 1'b0, addr: r_buf[6:3], data: r_word};
        mix_ctrl  = '{start: 1'b0, final_blk: r_final};
        o_stall   = !(r_state == S_IDLE && !r_restart);
        o_valid   = (r_state == S_OUT);

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_word = byte_mask(i_data.message_word, nb_eff);
                    n_nb   = nb_eff;
                    n_last = i_data.last_item;
                    if (nb_eff != 4'd0 && r_buf >= 8'(BLOCK_BYTES)) begin
                        add_en  = 1'b1;
                        n_buf   = '0;
                        n_final = 1'b0;
                    end
                end
            end
            S_STORE: begin
                if (r_nb != 4'd0) begin
                    ram_wr.en = 1'b1;
                    n_buf     = r_buf + {4'd0, r_nb};
                end
            end
            S_LAST: begin
                add_en  = 1'b1;
                add_n   = r_buf;
                n_pad   = pad_sum[7:3];
                n_final = 1'b1;
            end
            S_PAD: begin
                if (!r_pad[4]) begin
                    ram_wr = '{en: 1'b1, addr: r_pad[3:0], data: '0};
                    n_pad  = r_pad + 5'd1;
                end
            end
            S_CSTART: begin
                mix_ctrl.start = 1'b1;
            end
            S_CWAIT: begin
                if (mix_done) begin
                    for (int i = 0; i < 8; i++) begin
                        n_h[i] = r_h[i] ^ mix_v[i] ^ mix_v[i + 8];
                    end
                    n_k = '0;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    if (r_k == last_k) begin
                        n_restart = 1'b1;
                    end else begin
                        n_k = r_k + 3'd1;
                    end
                end
            end
            default: begin
            end
        endcase

        if (i_cfg_we) begin
            if (i_cfg_index == CFG_DIGEST_LEN) begin
                n_dlen    = i_cfg_data;
                n_restart = 1'b1;
            end else if (i_cfg_index == CFG_KEY_LEN) begin
                n_klen    = i_cfg_data;
                n_restart = 1'b1;
            end
        end

        if (r_restart) begin
            n_h    = IV;
            n_h[0] = IV[0] ^ PARAM_CONST ^ {49'd0, eff_klen(r_klen), 8'd0}
                     ^ {57'd0, eff_dlen(r_dlen)};
            n_buf  = '0;
        end
    end

    always_comb begin
        n_t0 = r_t0;
        n_t1 = r_t1;
        if (r_restart) begin
            n_t0 = '0;
            n_t1 = '0;
        end else if (add_en) begin
            n_t0 = t0_sum[63:0];
            n_t1 = r_t1 + {63'd0, t0_sum[64]};
        end
    end

    always_comb begin
        o_data.digest_word  = r_h[r_k];
        o_data.last_word    = (r_k == last_k);
        o_data.digest_bytes = (r_k == last_k) ? 4'(dl - {1'b0, r_k, 3'd0}) : 4'd8;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_buf     <= '0;
            r_t0      <= '0;
            r_t1      <= '0;
            r_pad     <= '0;
            r_k       <= '0;
            r_final   <= 1'b0;
            r_last    <= 1'b0;
            r_dlen    <= 7'd64;
            r_klen    <= 7'd0;
            r_restart <= 1'b1;
        end else begin
            r_state   <= n_state;
            r_buf     <= n_buf;
            r_t0      <= n_t0;
            r_t1      <= n_t1;
            r_pad     <= n_pad;
            r_k       <= n_k;
            r_final   <= n_final;
            r_last    <= n_last;
            r_dlen    <= n_dlen;
            r_klen    <= n_klen;
            r_restart <= n_restart;
        end
        r_h    <= n_h;
        r_word <= n_word;
        r_nb   <= n_nb;
    end

endmodule

// ----- bench/blake2b_hash_engine_top_tb.sv -----
// Self-checking bench for the BLAKE2b hash engine: directed and random messages, digest prediction.
// Depends on b2b_pkg and blake2b_hash_engine_top; holds its own hash model in a class.

// Digest predictor and store of expected digest words.
class b2b_digest_board;
    logic [6:0]  dlen_reg;
    logic [6:0]  klen_reg;
    logic [63:0] h [8];
    logic [63:0] buf_w [16];
    logic [63:0] cnt_lo;
    logic [63:0] cnt_hi;
    int unsigned fill;
    b2b_pkg::t_out pending [$];
    int errors;

    function new();
        dlen_reg = 7'd64;
        klen_reg = 7'd0;
        errors = 0;
        init_chain();
    endfunction

    function int unsigned dlen_eff();
        if (dlen_reg == 0) return 1;
        if (dlen_reg > 64) return 64;
        return dlen_reg;
    endfunction

    function void init_chain();
        logic [63:0] kl;
        kl = (klen_reg > 64) ? 64'd64 : 64'(klen_reg);
        for (int i = 0; i < 8; i++) h[i] = b2b_pkg::IV[i];
        h[0] ^= 64'h0101_0000 ^ (kl << 8) ^ 64'(dlen_eff());
        for (int i = 0; i < 16; i++) buf_w[i] = '0;
        cnt_lo = '0;
        cnt_hi = '0;
        fill = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [6:0] val);
        if (idx == b2b_pkg::CFG_DIGEST_LEN) dlen_reg = val;
        else if (idx == b2b_pkg::CFG_KEY_LEN) klen_reg = val;
        else return;
        init_chain();
    endfunction

    function logic [63:0] ror(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function void add_count(logic [63:0] n);
        cnt_lo += n;
        if (cnt_lo < n) cnt_hi += 1;
    endfunction

    function void compress(bit fin);
        logic [63:0] v [16];
        int a [8], b [8], c [8], d [8];
        int s;
        a = '{0, 1, 2, 3, 0, 1, 2, 3};
        b = '{4, 5, 6, 7, 5, 6, 7, 4};
        c = '{8, 9, 10, 11, 10, 11, 8, 9};
        d = '{12, 13, 14, 15, 15, 12, 13, 14};
        for (int i = 0; i < 8; i++) begin
            v[i] = h[i];
            v[i+8] = b2b_pkg::IV[i];
        end
        v[12] ^= cnt_lo;
        v[13] ^= cnt_hi;
        if (fin) v[14] = ~v[14];
        for (int r = 0; r < 12; r++) begin
            s = r % 10;
            for (int g = 0; g < 8; g++) begin
                v[a[g]] = v[a[g]] + v[b[g]] + buf_w[b2b_pkg::SIGMA[s][2*g]];
                v[d[g]] = ror(v[d[g]] ^ v[a[g]], 32);
                v[c[g]] = v[c[g]] + v[d[g]];
                v[b[g]] = ror(v[b[g]] ^ v[c[g]], 24);
                v[a[g]] = v[a[g]] + v[b[g]] + buf_w[b2b_pkg::SIGMA[s][2*g+1]];
                v[d[g]] = ror(v[d[g]] ^ v[a[g]], 16);
                v[c[g]] = v[c[g]] + v[d[g]];
                v[b[g]] = ror(v[b[g]] ^ v[c[g]], 63);
            end
        end
        for (int i = 0; i < 8; i++) h[i] ^= v[i] ^ v[i+8];
    endfunction

    // Notes an accepted message transaction and queues any digest words it completes.
    function void note_input(b2b_pkg::t_in t);
        int unsigned nb, dl, words;
        logic [63:0] w;
        b2b_pkg::t_out o;
        nb = t.valid_bytes;
        if (!t.last_item || nb > 8) nb = 8;
        w = t.message_word;
        if (nb > 0) begin
            if (fill >= 128) begin
                add_count(128);
                compress(0);
                fill = 0;
            end
            if (nb < 8) w &= (64'd1 << (8 * nb)) - 1;
            buf_w[(fill >> 3) & 15] = w;
            fill += nb;
        end
        if (!t.last_item) return;
        add_count(64'(fill));
        for (int i = (fill + 7) >> 3; i < 16; i++) buf_w[i] = '0;
        compress(1);
        dl = dlen_eff();
        words = (dl + 7) >> 3;
        for (int k = 0; k < words; k++) begin
            o.digest_word = h[k];
            o.digest_bytes = (k + 1 == words) ? 4'(dl - 8 * k) : 4'd8;
            o.last_word = (k + 1 == words);
            pending.push_back(o);
        end
        init_chain();
    endfunction

    // Compares a digest transaction with the oldest expected word.
    function void check_output(b2b_pkg::t_out got);
        b2b_pkg::t_out exp_w;
        logic [63:0] mask;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: unexpected digest word %h", got.digest_word);
            return;
        end
        exp_w = pending.pop_front();
        // Bytes past digest_bytes are don't-care.
        mask = (exp_w.digest_bytes >= 8) ? '1 : (64'd1 << (8 * exp_w.digest_bytes)) - 1;
        if (((got.digest_word ^ exp_w.digest_word) & mask) != 0
            || got.digest_bytes != exp_w.digest_bytes || got.last_word != exp_w.last_word) begin
            errors++;
            if (errors <= 10)
                $display("ERROR: digest exp %h/%0d/%0d got %h/%0d/%0d",
                         exp_w.digest_word, exp_w.digest_bytes, exp_w.last_word,
                         got.digest_word, got.digest_bytes, got.last_word);
        end
    endfunction
endclass

module blake2b_hash_engine_top_tb;
    import b2b_pkg::*;

    // Longest stretch with no transaction on either side: it must cover a full-digest
    // compression, and the sender or receiver may add a long gap on top.
    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in         in_data;
    logic        out_valid;
    logic        out_stall;
    t_out        out_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [6:0]  cfg_data;

    b2b_digest_board board;
    int idle_cycles;
    bit stim_done;
    bit sink_busy;

    blake2b_hash_engine_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_data      (in_data),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_data      (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Mostly short gaps, now and then a long one, sometimes none at all.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sample at the rising edge: accepted transactions feed the scoreboard.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) board.note_input(in_data);
            if (out_valid && !out_stall) board.check_output(out_data);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Receiver stall pattern, changed at the falling edge.
    always @(negedge clk) begin
        if (sink_busy) begin
            out_stall <= ($urandom_range(0, 3) == 0);
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Drives one message transaction and holds it until the engine takes it.
    // The engine stalls the input in its store step after every accepted word, so the
    // extra falling edge before driving still allows the fastest input rate.
    task automatic send_word(logic [63:0] w, logic [3:0] nb, logic lst);
        int g;
        g = gap_len();
        repeat (g + 1) @(negedge clk);
        in_valid <= 1'b1;
        in_data <= '{message_word: w, valid_bytes: nb, last_item: lst};
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Waits for all digest words to drain, then writes one register.
    task automatic write_cfg(logic [1:0] idx, logic [6:0] val);
        while (board.pending.size() != 0) @(negedge clk);
        repeat (600) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.write_reg(idx, val);
    endtask

    // Sends a message of nwords full words plus a final word with tail bytes.
    task automatic send_message(int nwords, logic [3:0] tail);
        logic [63:0] w;
        for (int i = 0; i < nwords; i++) begin
            w = {$urandom, $urandom};
            send_word(w, 4'($urandom_range(0, 15)), 1'b0);
        end
        send_word({$urandom, $urandom}, tail, 1'b1);
    endtask

    initial begin
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_DIGEST_LEN;
        cfg_data = '0;
        idle_cycles = 0;
        stim_done = 0;
        sink_busy = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: empty message, extreme words, block edges, tail byte counts.
        send_word('0, 4'd0, 1'b1);
        send_word('1, 4'd8, 1'b1);
        send_word('1, 4'd15, 1'b1);
        send_message(15, 4'd8);
        send_message(16, 4'd0);
        send_message(16, 4'd3);
        write_cfg(CFG_DIGEST_LEN, 7'd1);
        send_word(64'h0123_4567_89ab_cdef, 4'd5, 1'b1);
        write_cfg(CFG_DIGEST_LEN, 7'd0);
        write_cfg(CFG_KEY_LEN, 7'd127);
        send_word(64'hfedc_ba98_7654_3210, 4'd1, 1'b1);
        write_cfg(CFG_DIGEST_LEN, 7'd100);
        write_cfg(CFG_KEY_LEN, 7'd64);
        send_message(16, 4'd7);

        // A register write mid-message discards the partial message.
        send_word('1, 4'd8, 1'b0);
        write_cfg(CFG_KEY_LEN, 7'd0);

        // Random part with shifting settings and receiver stalls.
        sink_busy = 1;
        for (int m = 0; m < 36; m++) begin
            if (m % 6 == 5) begin
                write_cfg(CFG_DIGEST_LEN, 7'($urandom_range(0, 127)));
                write_cfg(CFG_KEY_LEN, 7'($urandom_range(0, 127)));
            end
            if ($urandom_range(0, 4) == 0) begin
                send_message($urandom_range(15, 33), 4'($urandom_range(0, 15)));
            end else begin
                send_message($urandom_range(0, 6), 4'($urandom_range(0, 15)));
            end
        end

        while (board.pending.size() != 0) @(negedge clk);
        sink_busy = 0;
        repeat (50) @(negedge clk);
        if (board.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
